### design/websocket_frame_deframer_unit_defines.svh
// assertion macros shared by the deframer rtl
// no dependencies; include by bare file name inside a module body
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define WFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wfd_pkg.sv
// types and constants for the web-socket frame deframer
// no dependencies
`default_nettype none

package wfd_pkg;

  localparam int unsigned MaxPayloadW = 31;
  localparam int unsigned LenW        = 64;

  localparam logic [MaxPayloadW-1:0] MAX_PAYLOAD_RESET = 31'd2147483646;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_RSV        = 4'd1;
  localparam logic [3:0] ERR_OPCODE     = 4'd2;
  localparam logic [3:0] ERR_CTRL_BIG   = 4'd3;
  localparam logic [3:0] ERR_CTRL_FRAG  = 4'd4;
  localparam logic [3:0] ERR_SHORT16    = 4'd5;
  localparam logic [3:0] ERR_MSB        = 4'd6;
  localparam logic [3:0] ERR_SHORT64    = 4'd7;
  localparam logic [3:0] ERR_TOO_LARGE  = 4'd8;

  // opcodes
  localparam logic [3:0] OPC_DATA_RSVD_LO = 4'd3;
  localparam logic [3:0] OPC_DATA_RSVD_HI = 4'd7;
  localparam logic [3:0] OPC_CLOSE        = 4'd8;
  localparam logic [3:0] OPC_CTRL_RSVD_LO = 4'd11;
  localparam logic [3:0] OPC_CTRL_RSVD_HI = 4'd15;

  // short length codes
  localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;

  localparam logic [2:0] LEN16_BYTES = 3'd2;
  localparam logic [2:0] MASK_BYTES  = 3'd4;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_LEN16   = 6'b000100,
    PH_LEN64   = 6'b001000,
    PH_MASK    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

endpackage

`default_nettype wire

### design/websocket_frame_deframer_unit.sv
// web-socket frame deframer: header/length/mask parser with payload unmasking
// depends on wfd_pkg and websocket_frame_deframer_unit_defines.svh
//
// Takes one stream byte per cycle when not stalled and gives at most one result
// per byte. An accepted byte lands in an input register; the parser then updates
// its state and writes any result to the output register once that register is
// free. Throughput is one byte per clock while nothing stalls, set by
// the combinational parser step between the input and output registers; a stall
// on the output holds the input register, which then stalls the input. The
// payload limit may be written at any time through the configuration channel,
// which is always ready, but should only change while no frame is in flight.
`default_nettype none

module websocket_frame_deframer_unit
  import wfd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // byte input
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             data_byte,
  // result output
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  payload_byte,
  output logic [3:0]                  frame_opcode,
  output logic                        final_fragment,
  output logic                        last,
  output logic [3:0]                  error_code,
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [MaxPayloadW-1:0] max_payload_bytes
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_go;
  logic       step;

  // parser state
  phase_t                 phase, phase_next;
  logic [2:0]             count, count_next;
  logic [LenW-1:0]        acc, acc_next;
  logic [31:0]            mask_key, mask_key_next;
  logic                   mask_en, mask_en_next;
  logic [3:0]             opcode_held, opcode_held_next;
  logic                   fin_held, fin_held_next;
  logic                   rsv_seen, rsv_seen_next;
  logic [MaxPayloadW-1:0] remaining, remaining_next;
  logic [1:0]             mask_index, mask_index_next;
  logic [MaxPayloadW-1:0] max_payload_limit;

  // step results
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_last;
  logic [3:0] res_err;
  logic       fail;
  logic [3:0] fail_code;
  logic       after_length;
  logic       enter_payload;
  logic       too_big;
  logic [6:0] len7;
  logic [7:0] key_byte;

  assign cfg_ready = 1'b1;
  assign s1_go     = !out_valid || !out_stall;
  assign step      = s1_valid && s1_go;
  assign in_stall  = s1_valid && !s1_go;
  assign len7      = s1_byte[6:0];

  always_comb begin
    phase_next       = phase;
    count_next       = count;
    acc_next         = acc;
    mask_key_next    = mask_key;
    mask_en_next     = mask_en;
    opcode_held_next = opcode_held;
    fin_held_next    = fin_held;
    rsv_seen_next    = rsv_seen;
    remaining_next   = remaining;
    mask_index_next  = mask_index;
    res_valid        = 1'b0;
    res_kind         = KIND_PAYLOAD;
    res_byte         = 8'd0;
    res_last         = 1'b0;
    res_err          = ERR_NONE;
    fail             = 1'b0;
    fail_code        = ERR_NONE;
    after_length     = 1'b0;
    enter_payload    = 1'b0;
    key_byte         = 8'd0;

    case (phase)
      PH_HDR0: begin
        fin_held_next    = s1_byte[7];
        rsv_seen_next    = |s1_byte[6:4];
        opcode_held_next = s1_byte[3:0];
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        mask_en_next = s1_byte[7];
        acc_next     = {{(LenW-7){1'b0}}, len7};
        count_next   = 3'd0;
        if (rsv_seen) begin
          fail      = 1'b1;
          fail_code = ERR_RSV;
        end else if (opcode_held inside {[OPC_DATA_RSVD_LO:OPC_DATA_RSVD_HI],
                                         [OPC_CTRL_RSVD_LO:OPC_CTRL_RSVD_HI]}) begin
          fail      = 1'b1;
          fail_code = ERR_OPCODE;
        end else if (opcode_held >= OPC_CLOSE && len7 > LEN7_CTRL_MAX) begin
          fail      = 1'b1;
          fail_code = ERR_CTRL_BIG;
        end else if (opcode_held >= OPC_CLOSE && !fin_held) begin
          fail      = 1'b1;
          fail_code = ERR_CTRL_FRAG;
        end else if (len7 == LEN7_EXT16) begin
          acc_next   = '0;
          phase_next = PH_LEN16;
        end else if (len7 == LEN7_EXT64) begin
          acc_next   = '0;
          phase_next = PH_LEN64;
        end else begin
          after_length = 1'b1;
        end
      end
      PH_LEN16: begin
        acc_next   = {{(LenW-16){1'b0}}, acc[7:0], s1_byte};
        count_next = 3'(count + 3'd1);
        if (count_next == LEN16_BYTES) begin
          if (acc_next[15:0] < 16'(LEN7_EXT16)) begin
            fail      = 1'b1;
            fail_code = ERR_SHORT16;
          end else begin
            after_length = 1'b1;
          end
        end
      end
      PH_LEN64: begin
        acc_next   = {acc[LenW-9:0], s1_byte};
        count_next = 3'(count + 3'd1);
        if (count_next == 3'd0) begin
          if (acc_next[LenW-1]) begin
            fail      = 1'b1;
            fail_code = ERR_MSB;
          end else if (acc_next[LenW-1:16] == '0) begin
            fail      = 1'b1;
            fail_code = ERR_SHORT64;
          end else begin
            after_length = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], s1_byte};
        count_next    = 3'(count + 3'd1);
        if (count_next == MASK_BYTES) begin
          count_next    = 3'd0;
          enter_payload = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        // first key byte is the most significant one
        if (mask_en) begin
          case (mask_index)
            2'd0:    key_byte = mask_key[31:24];
            2'd1:    key_byte = mask_key[23:16];
            2'd2:    key_byte = mask_key[15:8];
            default: key_byte = mask_key[7:0];
          endcase
        end
        mask_index_next = 2'(mask_index + 2'd1);
        remaining_next  = MaxPayloadW'(remaining - 1'b1);
        res_valid       = 1'b1;
        res_kind        = KIND_PAYLOAD;
        res_byte        = s1_byte ^ key_byte;
        res_last        = (remaining_next == '0);
        if (res_last) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    if (after_length) begin
      count_next = 3'd0;
      if (mask_en_next) begin
        phase_next    = PH_MASK;
        mask_key_next = '0;
      end else begin
        enter_payload = 1'b1;
      end
    end

    too_big = (|acc_next[LenW-1:MaxPayloadW]) ||
              (acc_next[MaxPayloadW-1:0] > max_payload_limit);

    if (enter_payload) begin
      if (acc_next == '0) begin
        phase_next = PH_HDR0;
        res_valid  = 1'b1;
        res_kind   = KIND_EMPTY;
        res_last   = 1'b1;
      end else if (too_big) begin
        fail      = 1'b1;
        fail_code = ERR_TOO_LARGE;
      end else begin
        remaining_next  = acc_next[MaxPayloadW-1:0];
        mask_index_next = 2'd0;
        phase_next      = PH_PAYLOAD;
      end
    end

    if (fail) begin
      phase_next = PH_HDR0;
      count_next = 3'd0;
      res_valid  = 1'b1;
      res_kind   = KIND_ERROR;
      res_byte   = 8'd0;
      res_last   = 1'b1;
      res_err    = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      phase             <= PH_HDR0;
      count             <= 3'd0;
      acc               <= '0;
      mask_key          <= '0;
      mask_en           <= 1'b0;
      opcode_held       <= OPC_CLOSE;
      fin_held          <= 1'b1;
      rsv_seen          <= 1'b0;
      remaining         <= '0;
      mask_index        <= 2'd0;
      max_payload_limit <= MAX_PAYLOAD_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_payload_limit <= max_payload_bytes;
      end

      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (step && res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (step) begin
        phase       <= phase_next;
        count       <= count_next;
        acc         <= acc_next;
        mask_key    <= mask_key_next;
        mask_en     <= mask_en_next;
        opcode_held <= opcode_held_next;
        fin_held    <= fin_held_next;
        rsv_seen    <= rsv_seen_next;
        remaining   <= remaining_next;
        mask_index  <= mask_index_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
    if (step && res_valid) begin
      kind           <= res_kind;
      payload_byte   <= res_byte;
      frame_opcode   <= opcode_held;
      final_fragment <= fin_held;
      last           <= res_last;
      error_code     <= res_err;
    end
  end

  `include "websocket_frame_deframer_unit_defines.svh"

  `WFD_ASSERT_SAME(a_err_shape, clk, rst, out_valid && kind == KIND_ERROR, last && payload_byte == 8'd0 && error_code != ERR_NONE, "error result malformed")
  `WFD_ASSERT_SAME(a_code_only_on_err, clk, rst, out_valid && kind != KIND_ERROR, error_code == ERR_NONE, "error code on non-error result")
  `WFD_ASSERT_SAME(a_empty_last, clk, rst, out_valid && kind == KIND_EMPTY, last && payload_byte == 8'd0, "empty frame result not last")
  `WFD_ASSERT_NEXT(a_payload_emits, clk, rst, step && phase == PH_PAYLOAD, out_valid && kind == KIND_PAYLOAD, "payload byte gave no result")
  `WFD_ASSERT_SAME(a_stall_cause, clk, rst, in_stall, s1_valid && out_valid && out_stall, "input stalled without a blocked result")

endmodule

`default_nettype wire

### tb/sv/wfd_result_monitor.sv
// result monitor for the web-socket frame deframer: tracks the parse of the byte stream,
// predicts each result and checks it against the output channel
// depends on wfd_pkg
module wfd_result_monitor
  import wfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [1:0]             kind,
  input  logic [7:0]             payload_byte,
  input  logic [3:0]             frame_opcode,
  input  logic                   final_fragment,
  input  logic                   last,
  input  logic [3:0]             error_code,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [MaxPayloadW-1:0] max_payload_bytes,
  output int unsigned            mismatch_count,
  output int unsigned            results_owed,
  output logic                   at_frame_start
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    logic [3:0] err;
  } frame_result_t;

  frame_result_t           parsed_results[$];

  phase_t                  phase_q;
  logic [2:0]              cnt_q;
  logic [LenW-1:0]         len_q;
  logic [31:0]             key_q;
  logic                    masked_q;
  logic [3:0]              opc_q;
  logic                    fin_q;
  logic [MaxPayloadW-1:0]  remain_q;
  logic [1:0]              key_idx_q;
  logic                    rsv_q;
  logic [MaxPayloadW-1:0]  limit_q;

  assign at_frame_start = (phase_q == PH_HDR0);

  function automatic frame_result_t make_result(input logic [1:0] k, input logic [7:0] d,
                                                input logic l, input logic [3:0] e);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.opcode = opc_q;
    r.fin = fin_q;
    r.last = l;
    r.err = e;
    return r;
  endfunction

  function automatic bit reject_frame(input logic [3:0] e, output frame_result_t r);
    phase_q = PH_HDR0;
    cnt_q = '0;
    r = make_result(KIND_ERROR, 8'h00, 1'b1, e);
    return 1'b1;
  endfunction

  function automatic bit open_payload(output frame_result_t r);
    if (len_q == '0) begin
      phase_q = PH_HDR0;
      r = make_result(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
      return 1'b1;
    end
    if (len_q > LenW'(limit_q)) return reject_frame(ERR_TOO_LARGE, r);
    remain_q = len_q[MaxPayloadW-1:0];
    key_idx_q = '0;
    phase_q = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit close_length(output frame_result_t r);
    cnt_q = '0;
    if (masked_q) begin
      phase_q = PH_MASK;
      key_q = '0;
      return 1'b0;
    end
    return open_payload(r);
  endfunction

  // advances the parse by one stream byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [6:0] len7;
    logic [7:0] key_byte;
    case (phase_q)
      PH_HDR0: begin
        fin_q = b[7];
        rsv_q = |b[6:4];
        opc_q = b[3:0];
        phase_q = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        len7 = b[6:0];
        masked_q = b[7];
        len_q = LenW'(len7);
        cnt_q = '0;
        if (rsv_q) return reject_frame(ERR_RSV, r);
        if ((opc_q >= OPC_DATA_RSVD_LO && opc_q <= OPC_DATA_RSVD_HI) ||
            opc_q >= OPC_CTRL_RSVD_LO)
          return reject_frame(ERR_OPCODE, r);
        // control frames: size checked before fragmentation
        if (opc_q >= OPC_CLOSE) begin
          if (len7 > LEN7_CTRL_MAX) return reject_frame(ERR_CTRL_BIG, r);
          if (!fin_q) return reject_frame(ERR_CTRL_FRAG, r);
        end
        if (len7 == LEN7_EXT16) begin
          len_q = '0;
          phase_q = PH_LEN16;
          return 1'b0;
        end
        if (len7 == LEN7_EXT64) begin
          len_q = '0;
          phase_q = PH_LEN64;
          return 1'b0;
        end
        return close_length(r);
      end
      PH_LEN16: begin
        len_q = ((len_q << 8) | LenW'(b)) & 64'hFFFF;
        cnt_q = cnt_q + 3'd1;
        if (cnt_q < LEN16_BYTES) return 1'b0;
        if (len_q < LenW'(LEN7_EXT16)) return reject_frame(ERR_SHORT16, r);
        return close_length(r);
      end
      PH_LEN64: begin
        len_q = (len_q << 8) | LenW'(b);
        cnt_q = cnt_q + 3'd1;
        if (cnt_q != '0) return 1'b0;
        if (len_q[LenW-1]) return reject_frame(ERR_MSB, r);
        if (len_q <= 64'hFFFF) return reject_frame(ERR_SHORT64, r);
        return close_length(r);
      end
      PH_MASK: begin
        key_q = (key_q << 8) | 32'(b);
        cnt_q = cnt_q + 3'd1;
        if (cnt_q < MASK_BYTES) return 1'b0;
        cnt_q = '0;
        return open_payload(r);
      end
      PH_PAYLOAD: begin
        // first key byte is the most significant one
        key_byte = masked_q ? key_q[(3 - key_idx_q) * 8 +: 8] : 8'h00;
        key_idx_q = key_idx_q + 2'd1;
        remain_q = remain_q - 1'b1;
        if (remain_q == '0) phase_q = PH_HDR0;
        r = make_result(KIND_PAYLOAD, b ^ key_byte, remain_q == '0, ERR_NONE);
        return 1'b1;
      end
      default: begin
        phase_q = PH_HDR0;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    frame_result_t pred;
    if (rst) begin
      parsed_results.delete();
      phase_q = PH_HDR0;
      cnt_q = '0;
      len_q = '0;
      key_q = '0;
      masked_q = 1'b0;
      opc_q = OPC_CLOSE;
      fin_q = 1'b1;
      remain_q = '0;
      key_idx_q = '0;
      rsv_q = 1'b0;
      limit_q = MAX_PAYLOAD_RESET;
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = kind;
        got.data = payload_byte;
        got.opcode = frame_opcode;
        got.fin = final_fragment;
        got.last = last;
        got.err = error_code;
        if (parsed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h error %0d",
                   $time, got.kind, got.data, got.err);
          mismatch_count++;
        end else begin
          want = parsed_results.pop_front();
          compare_field("kind", want.kind, got.kind);
          compare_field("payload_byte", want.data, got.data);
          compare_field("frame_opcode", want.opcode, got.opcode);
          compare_field("final_fragment", want.fin, got.fin);
          compare_field("last", want.last, got.last);
          compare_field("error_code", want.err, got.err);
        end
      end
      if (in_valid && !in_stall) begin
        if (deframe_byte(data_byte, pred)) parsed_results.insert(parsed_results.size(), pred);
      end
      if (cfg_valid && cfg_ready) limit_q = max_payload_bytes;
    end
    results_owed = parsed_results.size();
  end

endmodule

### tb/sv/tb_websocket_frame_deframer_unit.sv
// top of the web-socket frame deframer bench: clock, reset, byte stream and limit writes
// with random gaps and output stalls; depends on wfd_pkg, wfd_result_monitor and the dut
module tb_websocket_frame_deframer_unit
  import wfd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned MAX_WAIT        = 18;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned PHASE_BYTES     = 230;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned NOISE_LIMIT_MAX = 400;
  localparam int unsigned TAIL_BYTES      = 20;

  localparam logic [3:0] OPC_CONT   = 4'd0;
  localparam logic [3:0] OPC_TEXT   = 4'd1;
  localparam logic [3:0] OPC_BINARY = 4'd2;
  localparam logic [3:0] OPC_PING   = 4'd9;
  localparam logic [3:0] OPC_PONG   = 4'd10;

  typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             data_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             kind;
  logic [7:0]             payload_byte;
  logic [3:0]             frame_opcode;
  logic                   final_fragment;
  logic                   last;
  logic [3:0]             error_code;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [MaxPayloadW-1:0] max_payload_bytes;

  int unsigned            mismatch_count;
  int unsigned            results_owed;
  logic                   at_frame_start;

  logic [MaxPayloadW-1:0] cur_limit;
  int unsigned            sent_bytes = 0;
  int unsigned            send_calm = 0;
  int unsigned            recv_calm = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  websocket_frame_deframer_unit dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .payload_byte      (payload_byte),
    .frame_opcode      (frame_opcode),
    .final_fragment    (final_fragment),
    .last              (last),
    .error_code        (error_code),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .max_payload_bytes (max_payload_bytes)
  );

  wfd_result_monitor u_monitor (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .payload_byte      (payload_byte),
    .frame_opcode      (frame_opcode),
    .final_fragment    (final_fragment),
    .last              (last),
    .error_code        (error_code),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .max_payload_bytes (max_payload_bytes),
    .mismatch_count    (mismatch_count),
    .results_owed      (results_owed),
    .at_frame_start    (at_frame_start)
  );

  // wait before the next item; now and then a run of back-to-back items
  function automatic int unsigned pick_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_wait(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_hdr(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                          input logic masked, input logic [6:0] len7);
    send_byte({fin, rsv, opc});
    send_byte({masked, len7});
  endtask

  // header, extended length, key and payload; stop_at_len leaves out key and payload
  task automatic send_frame(input logic fin, input logic [3:0] opc, input logic masked,
                            input len_form_t form, input logic [63:0] len,
                            input int unsigned npay, input bit stop_at_len);
    logic [6:0] code;
    code = (form == LEN_EXT16) ? LEN7_EXT16 : (form == LEN_EXT64) ? LEN7_EXT64 : len[6:0];
    send_hdr(fin, 3'b000, opc, masked, code);
    if (form == LEN_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (stop_at_len) return;
    if (masked) repeat (MASK_BYTES) send_byte(8'($urandom));
    repeat (npay) send_byte(8'($urandom));
  endtask

  // sender holds off until every pending result is out and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [MaxPayloadW-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    max_payload_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_limit = value;
  endtask

  // output back-pressure, independent of the stream
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = pick_wait(recv_calm);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ends the run when no channel moves for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [MaxPayloadW-1:0] phase_limit;
    int unsigned            phase_start;
    int unsigned            roll;
    int unsigned            pick;
    logic                   fin;
    logic                   masked;
    logic [3:0]             opc;
    logic [3:0]             data_opc;
    logic [3:0]             ctrl_opc;
    logic [6:0]             len7;
    logic [63:0]            len;
    len_form_t              form;

    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    cfg_valid = 1'b0;
    max_payload_bytes = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    write_limit(MAX_PAYLOAD_RESET);

    // directed: empty frame, masked payload, each header error, short 16-bit length,
    // empty frame ending on the key
    send_hdr(1'b1, 3'b000, OPC_TEXT, 1'b0, 7'd0);
    send_frame(1'b0, OPC_BINARY, 1'b1, LEN_SHORT, 64'd1, 1, 1'b0);
    send_hdr(1'b1, 3'b111, OPC_CTRL_RSVD_HI, 1'b1, LEN7_EXT64);
    send_hdr(1'b1, 3'b000, OPC_DATA_RSVD_LO, 1'b0, 7'd0);
    send_hdr(1'b0, 3'b000, OPC_CTRL_RSVD_LO, 1'b1, 7'd5);
    send_hdr(1'b1, 3'b000, OPC_PING, 1'b0, LEN7_EXT16);
    send_hdr(1'b0, 3'b000, OPC_PONG, 1'b0, 7'd0);
    send_frame(1'b1, OPC_BINARY, 1'b0, LEN_EXT16, 64'(LEN7_CTRL_MAX), 0, 1'b1);
    send_frame(1'b1, OPC_CLOSE, 1'b1, LEN_SHORT, 64'd0, 0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_limit = '0;
        1: phase_limit = 31'd1;
        2, 4: phase_limit = 31'($urandom_range(2, NOISE_LIMIT_MAX));
        3: phase_limit = 31'($urandom_range(NOISE_LIMIT_MAX + 1, MAX_PAYLOAD_RESET - 1));
        default: phase_limit = MAX_PAYLOAD_RESET;
      endcase
      write_limit(phase_limit);
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) begin
        roll = $urandom_range(0, 99);
        masked = 1'($urandom);
        fin = 1'($urandom);
        data_opc = 4'($urandom_range(OPC_CONT, OPC_BINARY));
        ctrl_opc = 4'($urandom_range(OPC_CLOSE, OPC_PONG));
        if (roll < 70) begin
          if ($urandom_range(0, 3) == 0) begin
            opc = ctrl_opc;
            fin = 1'b1;
            form = LEN_SHORT;
            len = ($urandom_range(0, 9) == 0) ? 64'(LEN7_CTRL_MAX) : 64'($urandom_range(0, 6));
          end else begin
            opc = data_opc;
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
              form = LEN_SHORT;
              len = 64'($urandom_range(0, 12));
            end else if (pick == 16) begin
              form = LEN_SHORT;
              len = 64'($urandom_range(13, LEN7_CTRL_MAX));
            end else if (pick == 19 && cur_limit <= NOISE_LIMIT_MAX) begin
              form = LEN_EXT16;
              len = 64'($urandom_range(LEN7_EXT16, 65535));
            end else begin
              form = LEN_EXT16;
              len = 64'($urandom_range(LEN7_EXT16, 260));
            end
          end
          // a frame over the limit is rejected before any payload
          send_frame(fin, opc, masked, form, len, (len > cur_limit) ? 0 : len[15:0], 1'b0);
        end else if (roll < 88 || cur_limit > NOISE_LIMIT_MAX) begin
          len7 = 7'($urandom);
          case ($urandom_range(0, 7))
            0: send_hdr(fin, 3'($urandom_range(1, 7)), 4'($urandom), masked, len7);
            1: begin
              opc = ($urandom_range(0, 1) != 0) ?
                    4'($urandom_range(OPC_DATA_RSVD_LO, OPC_DATA_RSVD_HI)) :
                    4'($urandom_range(OPC_CTRL_RSVD_LO, OPC_CTRL_RSVD_HI));
              send_hdr(fin, 3'b000, opc, masked, len7);
            end
            2: send_hdr(fin, 3'b000, ctrl_opc, masked,
                        7'($urandom_range(LEN7_EXT16, LEN7_EXT64)));
            3: send_hdr(1'b0, 3'b000, ctrl_opc, masked, 7'($urandom_range(0, LEN7_CTRL_MAX)));
            4: send_frame(fin, data_opc, masked, LEN_EXT16,
                          64'($urandom_range(0, LEN7_CTRL_MAX)), 0, 1'b1);
            5: begin
              len = {$urandom, $urandom};
              len[63] = 1'b1;
              send_frame(fin, data_opc, masked, LEN_EXT64, len, 0, 1'b1);
            end
            6: send_frame(fin, data_opc, masked, LEN_EXT64, 64'($urandom_range(0, 65535)), 0,
                          1'b1);
            default: begin
              // well-formed 64-bit length beyond any limit
              len = {$urandom, $urandom};
              len[63] = 1'b0;
              len[32] = 1'b1;
              send_frame(fin, data_opc, masked, LEN_EXT64, len, 0, 1'b0);
            end
          endcase
        end else begin
          // random bytes, then feed more until the parser is back at a frame start
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
          while (!at_frame_start) send_byte(8'($urandom));
        end
      end
    end

    // start of a frame with a full 64-bit length; only its first bytes are sent
    send_frame(1'b1, OPC_BINARY, 1'b1, LEN_EXT64, 64'd65536, TAIL_BYTES, 1'b0);
    drain_results();

    if (mismatch_count == 0 && results_owed == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
